### design/adjacency_graph_bfs_engine_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency graph search engine
// Shared checks, each clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_GRAPH_BFS_ENGINE_DEFINES_SVH
`define ADJACENCY_GRAPH_BFS_ENGINE_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define AGBFS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that implies another at the same edge.
`define AGBFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another at the following edge.
`define AGBFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/agbfs_pkg.sv
// ----------------------------------------------------------------------------
// Adjacency graph search engine package
// Sizes, operation codes, sequencer states and the lowest-set-bit finder.
// ----------------------------------------------------------------------------
package agbfs_pkg;

    // Graph size and derived widths.
    localparam int NODES = 16;
    localparam int IDX_W = $clog2(NODES);
    localparam int PTR_W = $clog2(NODES + 1);

    // Fixed field widths.
    localparam int MODE_W     = 3;
    localparam int NODE_FLD_W = 4;
    localparam int ROW_FLD_W  = 16;

    // Stream widths.
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = MODE_W;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 1;

    // Operation codes carried on the input tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 3'd0,
        MODE_INFECT  = 3'd1,
        MODE_ISOLATE = 3'd2,
        MODE_QUERY   = 3'd3,
        MODE_SEARCH  = 3'd4
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLY,
        ST_FETCH,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Index of the lowest set bit; zero for an empty vector.
    function automatic logic [IDX_W-1:0] first_set(input logic [NODES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### design/adjacency_graph_bfs_engine.sv
// ----------------------------------------------------------------------------
// Adjacency graph breadth-first search engine
// Bit adjacency matrix with infected flags, row load, infect, isolate, query
// and breadth-first search that streams out the tree edges.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the s_axis channel: tuser holds the operation, tdata the
// node index and a row for loads. Results leave on the m_axis channel, with
// tlast on the final result of a command and tuser set on a tree edge.
// Load, infect and isolate take effect when accepted and produce no result.
// A query result is loaded into the output register from the reply state once
// the output is free. A search fetches one adjacency row per dequeued node,
// takes each discovered child in turn through the shared lowest-set-bit
// finder and then leaves the row.
// s_axis_tready is high only while the sequencer is idle; one command is in
// work at a time. Edges are held one deep so that tlast can mark the final
// edge; when the receiver stalls, the search waits with the edge in hand.
// Reset clears the matrix, the infected and visited flags and all handshake
// state; the block is idle and takes commands as soon as reset is released.
// ----------------------------------------------------------------------------
`include "adjacency_graph_bfs_engine_defines.svh"

module adjacency_graph_bfs_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] node, [19:4] row_bits, [23:20] zero
    input  logic [agbfs_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [2:0] mode
    input  logic [agbfs_pkg::S_USER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] parent, [7:4] child, [8] node_infected, [24:9] neighbor_bits,
    // [40:25] infected_mask, [47:41] zero
    output logic [agbfs_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    // [0] edge_valid
    output logic [agbfs_pkg::M_USER_W-1:0] m_axis_tuser
);
    import agbfs_pkg::*;

    // Stored graph and search state.
    logic [NODES-1:0] adj_reg [NODES];
    logic [IDX_W-1:0] queue_reg [NODES];
    logic [NODES-1:0] infected_reg, infected_next;
    logic [NODES-1:0] visited_reg, visited_next;
    logic [NODES-1:0] frontier_reg, frontier_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] parent_reg, parent_next;
    logic [IDX_W-1:0] node_reg, node_next;
    logic             node_ok_reg, node_ok_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_parent_reg, pend_parent_next;
    logic [IDX_W-1:0] pend_child_reg, pend_child_next;
    state_t           state_reg, state_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]     m_parent_reg, m_parent_next;
    logic [IDX_W-1:0]     m_child_reg, m_child_next;
    logic                 m_edge_reg, m_edge_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_inf_reg, m_inf_next;
    logic [ROW_FLD_W-1:0] m_nb_reg, m_nb_next;
    logic [ROW_FLD_W-1:0] m_mask_reg, m_mask_next;

    // Input decode.
    logic                  in_accept;
    mode_t                 in_mode;
    logic [NODE_FLD_W-1:0] in_node;
    logic [ROW_FLD_W-1:0]  in_row;
    logic                  in_ok;
    logic [IDX_W-1:0]      in_idx;

    // Control strobes.
    logic             out_free;
    logic             do_fetch;
    logic             do_scan;
    logic             do_reply;
    logic             do_finish;
    logic             out_load;
    logic [IDX_W-1:0] rd_idx;
    logic [NODES-1:0] rd_row;
    logic [IDX_W-1:0] scan_bit;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_mode   = mode_t'(s_axis_tuser);
    assign in_node   = s_axis_tdata[NODE_FLD_W-1:0];
    assign in_row    = s_axis_tdata[NODE_FLD_W +: ROW_FLD_W];
    assign in_ok     = int'(in_node) < NODES;
    assign in_idx    = in_node[IDX_W-1:0];
    assign out_free  = !m_valid_reg || m_axis_tready;

    // Single row read port: the queue head while fetching, else the held node.
    assign rd_idx   = (state_reg == ST_FETCH) ? queue_reg[head_reg[IDX_W-1:0]] : node_reg;
    assign rd_row   = adj_reg[rd_idx];
    // Shared lowest-set-bit finder over the pending children.
    assign scan_bit = first_set(frontier_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_mode == MODE_QUERY)
                begin
                    state_next = ST_REPLY;
                end
                else if (in_accept && in_mode == MODE_SEARCH)
                begin
                    state_next = in_ok ? ST_FETCH : ST_FINISH;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = (head_reg == tail_reg) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (frontier_reg == '0)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        do_fetch      = 1'b0;
        do_scan       = 1'b0;
        do_reply      = 1'b0;
        do_finish     = 1'b0;
        case (state_reg)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_REPLY:  do_reply      = out_free;
            ST_FETCH:  do_fetch      = head_reg != tail_reg;
            ST_SCAN:   do_scan       = (frontier_reg != '0) && (!pend_valid_reg || out_free);
            ST_FINISH: do_finish     = out_free;
            default:   s_axis_tready = 1'b0;
        endcase
    end

    assign out_load = do_reply || do_finish || (do_scan && pend_valid_reg);

    // Search and flag state.
    always_comb
    begin
        infected_next    = infected_reg;
        visited_next     = visited_reg;
        frontier_next    = frontier_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        parent_next      = parent_reg;
        node_next        = node_reg;
        node_ok_next     = node_ok_reg;
        pend_valid_next  = pend_valid_reg;
        pend_parent_next = pend_parent_reg;
        pend_child_next  = pend_child_reg;

        if (in_accept)
        begin
            node_next    = in_idx;
            node_ok_next = in_ok;
            if (in_mode == MODE_INFECT && in_ok)
            begin
                infected_next[in_idx] = 1'b1;
            end
            if (in_mode == MODE_SEARCH)
            begin
                visited_next    = '0;
                head_next       = '0;
                tail_next       = '0;
                pend_valid_next = 1'b0;
                if (in_ok)
                begin
                    visited_next[in_idx] = 1'b1;
                    tail_next            = PTR_W'(1);
                end
            end
        end

        // Dequeue one node and take its unvisited neighbors as children.
        if (do_fetch)
        begin
            frontier_next = rd_row & ~visited_reg;
            visited_next  = visited_reg | rd_row;
            parent_next   = rd_idx;
            head_next     = head_reg + PTR_W'(1);
        end

        // Emit the lowest pending child and enqueue it.
        if (do_scan)
        begin
            frontier_next[scan_bit] = 1'b0;
            tail_next               = tail_reg + PTR_W'(1);
            pend_valid_next         = 1'b1;
            pend_parent_next        = parent_reg;
            pend_child_next         = scan_bit;
        end

        if (do_finish)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // Output register loading.
    always_comb
    begin
        m_valid_next  = m_axis_tready ? 1'b0 : m_valid_reg;
        m_parent_next = m_parent_reg;
        m_child_next  = m_child_reg;
        m_edge_next   = m_edge_reg;
        m_last_next   = m_last_reg;
        m_inf_next    = m_inf_reg;
        m_nb_next     = m_nb_reg;
        m_mask_next   = m_mask_reg;
        if (out_load)
        begin
            m_valid_next  = 1'b1;
            m_mask_next   = ROW_FLD_W'(infected_reg);
            m_parent_next = '0;
            m_child_next  = '0;
            m_edge_next   = 1'b0;
            m_last_next   = 1'b1;
            m_inf_next    = 1'b0;
            m_nb_next     = '0;
            if (do_reply)
            begin
                m_inf_next = node_ok_reg && infected_reg[node_reg];
                m_nb_next  = node_ok_reg ? ROW_FLD_W'(rd_row) : '0;
            end
            else if (pend_valid_reg)
            begin
                // A held edge is final only when the search has run out.
                m_parent_next = pend_parent_reg;
                m_child_next  = pend_child_reg;
                m_edge_next   = 1'b1;
                m_last_next   = do_finish;
            end
        end
    end

    // Control and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            infected_reg   <= '0;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            infected_reg   <= infected_next;
            visited_reg    <= visited_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        frontier_reg    <= frontier_next;
        parent_reg      <= parent_next;
        node_reg        <= node_next;
        node_ok_reg     <= node_ok_next;
        pend_parent_reg <= pend_parent_next;
        pend_child_reg  <= pend_child_next;
        m_parent_reg    <= m_parent_next;
        m_child_reg     <= m_child_next;
        m_edge_reg      <= m_edge_next;
        m_last_reg      <= m_last_next;
        m_inf_reg       <= m_inf_next;
        m_nb_reg        <= m_nb_next;
        m_mask_reg      <= m_mask_next;
    end

    // Adjacency matrix: row load, and row plus column clear on isolate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (in_accept && in_ok)
        begin
            if (in_mode == MODE_LOAD)
            begin
                adj_reg[in_idx] <= NODES'(in_row);
            end
            else if (in_mode == MODE_ISOLATE)
            begin
                for (int i = 0; i < NODES; i++)
                begin
                    if (IDX_W'(i) == in_idx)
                    begin
                        adj_reg[i] <= '0;
                    end
                    else
                    begin
                        adj_reg[i][in_idx] <= 1'b0;
                    end
                end
            end
        end
    end

    // Search queue: root at the start, each child at the tail.
    always_ff @(posedge clk)
    begin
        if (in_accept && in_mode == MODE_SEARCH && in_ok)
        begin
            queue_reg[0] <= in_idx;
        end
        else if (do_scan)
        begin
            queue_reg[tail_reg[IDX_W-1:0]] <= scan_bit;
        end
    end

    // Port drive.
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = M_USER_W'(m_edge_reg);
    assign m_axis_tdata  = M_DATA_W'({m_mask_reg, m_nb_reg, m_inf_reg, m_child_reg, m_parent_reg});

    // Checks.
    `AGBFS_ASSERT_ALWAYS(a_queue_order, head_reg <= tail_reg, "queue head passed the tail")
    `AGBFS_ASSERT_ALWAYS(a_queue_bound, tail_reg <= PTR_W'(NODES), "queue overran its depth")
    `AGBFS_ASSERT_SAME(a_pend_in_search, pend_valid_reg,
        state_reg == ST_FETCH || state_reg == ST_SCAN || state_reg == ST_FINISH,
        "held edge outside a search")
    `AGBFS_ASSERT_NEXT(a_scan_enqueues, do_scan, tail_reg == $past(tail_reg) + PTR_W'(1),
        "child not enqueued")
    `AGBFS_ASSERT_SAME(a_no_overwrite, !out_free, !out_load, "result overwritten while stalled")

endmodule
